// ===== rtl/fkc_pkg.sv =====
// ============================================================================
// FNV keystream cipher package
// Shared constants, codes, item types and the FNV prime multiply.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fkc_pkg;

  localparam int          KEY_DEPTH_DEF = 128;
  localparam int          SLOT_W        = 7;
  localparam int          BYTE_W        = 8;
  localparam int          HASH_W        = 64;
  localparam int          CFG_IDX_W     = 1;
  localparam int          IN_DATA_W     = 24;
  localparam int          IN_USER_W     = 2;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED  = 1'b1;

  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_DATA = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              len_zero;
  } s1_item_t;

  // The 64-bit FNV prime is 2^40 + 2^8 + 0xB3, so the product is a sum of shifts.
  function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
    fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fkc_key_store.sv =====
// ============================================================================
// FNV keystream cipher key store
// Simple dual-port key byte memory with a registered, enabled read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fkc_key_store #(
  parameter int KEY_DEPTH = fkc_pkg::KEY_DEPTH_DEF,
  parameter int ADDR_W    = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [ADDR_W-1:0]           wr_addr_i,
  input  wire logic [fkc_pkg::BYTE_W-1:0]  wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [ADDR_W-1:0]           rd_addr_i,
  output      logic [fkc_pkg::BYTE_W-1:0]  rd_data_o
);
  import fkc_pkg::*;

  logic [BYTE_W-1:0] mem_q [KEY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fkc_mix.sv =====
// ============================================================================
// FNV keystream cipher mixing stage
// Rolling FNV-1a hash update, keystream XOR and the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fkc_mix (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire fkc_pkg::s1_item_t           item_i,
  input  wire logic [fkc_pkg::BYTE_W-1:0]  key_i,
  input  wire logic [fkc_pkg::HASH_W-1:0]  seed_i,
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output      logic [fkc_pkg::BYTE_W-1:0]  m_axis_tdata   // [7:0] out_byte
);
  import fkc_pkg::*;

  logic              take;
  logic [HASH_W-1:0] hash_q, hash_d, base;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_q, out_d;

  assign in_ready_o = !out_valid_q || m_axis_tready;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    base = item_i.first ? seed_i : hash_q;
    if (item_i.len_zero) begin
      hash_d = base;
      out_d  = item_i.data;
    end else begin
      hash_d = fnv_mul(base ^ HASH_W'(key_i));
      out_d  = item_i.data ^ hash_d[BYTE_W-1:0];
    end
    if (take) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= FNV_BASIS;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        hash_q <= hash_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.len_zero) |=> (m_axis_tdata == $past(item_i.data)))
    else $error("pass-through item changed its byte");

  a_restart_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.first && item_i.len_zero) |=> (hash_q == $past(seed_i)))
    else $error("first item did not restart the hash from the seed");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(hash_q))
    else $error("hash moved without an item");

endmodule

`default_nettype wire

// ===== rtl/fnv_keystream_xor_cipher.sv =====
// ============================================================================
// FNV keystream XOR cipher
// Byte stream cipher that XORs each data byte with a rolling FNV-1a hash; with a zero key length bytes pass unchanged.
// ============================================================================
// A data item passes an input register and then a result register; back-pressure
// on m_axis_tready can hold it in the input register before its result is valid.
// Throughput: one item per cycle unless the output stalls; the shift-add multiply
// feeds the hash register. Key load items write the key store and give no result.
// Reset clears the key length, sets seed and hash to the FNV-1a offset basis and
// the key position to zero; the key store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module fnv_keystream_xor_cipher #(
  parameter int KEY_DEPTH = fkc_pkg::KEY_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fkc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fkc_pkg::HASH_W-1:0]     cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [fkc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [6:0] key_slot,
                                                             // [14:7] key_value,
                                                             // [22:15] data_byte
  input  wire logic [fkc_pkg::IN_USER_W-1:0]  s_axis_tuser,  // [0] cmd, [1] first
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output      logic [fkc_pkg::BYTE_W-1:0]     m_axis_tdata   // [7:0] out_byte
);
  import fkc_pkg::*;

  localparam int ADDR_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  logic [BYTE_W-1:0] key_len_q;
  logic [HASH_W-1:0] seed_q;
  logic [ADDR_W-1:0] pos_q, pos_d, start_pos, use_pos;
  logic [ADDR_W:0]   inc_pos;
  logic [BYTE_W-1:0] eff_len;
  logic              len_zero;

  cmd_e              in_cmd;
  logic              in_first;
  logic [SLOT_W-1:0] in_slot;
  logic [BYTE_W-1:0] in_kval, in_data;
  logic              in_acc, data_acc, key_wr;

  logic              s1_valid_q, s1_valid_d;
  s1_item_t          s1_item_q;
  logic [BYTE_W-1:0] s1_key;
  logic              mix_ready;

  assign in_cmd   = cmd_e'(s_axis_tuser[0]);
  assign in_first = s_axis_tuser[1];
  assign in_slot  = s_axis_tdata[6:0];
  assign in_kval  = s_axis_tdata[14:7];
  assign in_data  = s_axis_tdata[22:15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= '0;
      seed_q    <= FNV_BASIS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_LENGTH: key_len_q <= cfg_data_i[BYTE_W-1:0];
        REG_HASH_SEED:  seed_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_len  = (32'(key_len_q) > 32'(KEY_DEPTH)) ? BYTE_W'(KEY_DEPTH) : key_len_q;
  assign len_zero = (eff_len == '0);

  assign s_axis_tready = !s1_valid_q || mix_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign data_acc      = in_acc && (in_cmd == CMD_DATA);
  assign key_wr        = in_acc && (in_cmd == CMD_KEY) && (32'(in_slot) < 32'(KEY_DEPTH));

  always_comb begin
    start_pos = in_first ? '0 : pos_q;
    use_pos   = (32'(start_pos) >= 32'(eff_len)) ? '0 : start_pos;
    inc_pos   = {1'b0, use_pos} + (ADDR_W + 1)'(1);
    if (len_zero) begin
      pos_d = start_pos;
    end else if (32'(inc_pos) >= 32'(eff_len)) begin
      pos_d = '0;
    end else begin
      pos_d = inc_pos[ADDR_W-1:0];
    end
    if (data_acc) begin
      s1_valid_d = 1'b1;
    end else if (mix_ready) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (data_acc) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      s1_item_q.data     <= in_data;
      s1_item_q.first    <= in_first;
      s1_item_q.len_zero <= len_zero;
    end
  end

  fkc_key_store #(
    .KEY_DEPTH (KEY_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_key_store (
    .clk_i     (clk_i),
    .wr_en_i   (key_wr),
    .wr_addr_i (ADDR_W'(in_slot)),
    .wr_data_i (in_kval),
    .rd_en_i   (data_acc),
    .rd_addr_i (use_pos),
    .rd_data_o (s1_key)
  );

  fkc_mix u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s1_valid_q),
    .in_ready_o    (mix_ready),
    .item_i        (s1_item_q),
    .key_i         (s1_key),
    .seed_i        (seed_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < 32'(KEY_DEPTH))
    else $error("key position beyond the key store");

  a_first_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_acc && in_first && len_zero) |=> (pos_q == '0))
    else $error("first item did not restart the key position");

  a_key_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_cmd == CMD_KEY) && !s1_valid_q) |=> !s1_valid_q)
    else $error("key load item entered the data path");

  a_len_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_acc && !len_zero && (eff_len == 8'd1)) |=> (pos_q == '0))
    else $error("single byte key did not hold position zero");

endmodule

`default_nettype wire
